// ----- sv/u8kana_pkg.sv -----
// Shared constants and the katakana lookup tables for the UTF-8 to half-width kana converter.
`default_nettype none

package u8kana_pkg;

  // Byte values that frame a katakana sequence.
  localparam logic [7:0] LEAD_BYTE   = 8'hE3;
  localparam logic [7:0] PAGE_LOW    = 8'h82;
  localparam logic [7:0] PAGE_HIGH   = 8'h83;
  localparam logic [7:0] VOICED_MARK = 8'hDE;
  localparam logic [7:0] SEMI_MARK   = 8'hDF;
  localparam logic [7:0] NO_KANA     = 8'h00;

  // Prefix bits of a UTF-8 continuation byte.
  localparam logic [1:0] CONT_PREFIX = 2'b10;

  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  typedef logic [IDX_W-1:0] kana_idx_t;

  // Base kana indexed by {page, low six bits of the third byte}.
  // The first 64 entries belong to page 82, the next 64 to page 83.
  localparam logic [7:0] KANA_BASE [TABLE_DEPTH] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'hA7, 8'hB1, 8'hA8, 8'hB2, 8'hA9, 8'hB3, 8'hAA,
    8'hB4, 8'hAB, 8'hB5, 8'hB6, 8'hB6, 8'hB7, 8'hB7, 8'hB8,
    8'hB8, 8'hB9, 8'hB9, 8'hBA, 8'hBA, 8'hBB, 8'hBB, 8'hBC,
    8'hBC, 8'hBD, 8'hBD, 8'hBE, 8'hBE, 8'hBF, 8'hBF, 8'hC0,
    8'hC0, 8'hC1, 8'hC1, 8'hAF, 8'hC2, 8'hC2, 8'hC3, 8'hC3,
    8'hC4, 8'hC4, 8'hC5, 8'hC6, 8'hC7, 8'hC8, 8'hC9, 8'hCA,
    8'hCA, 8'hCA, 8'hCB, 8'hCB, 8'hCB, 8'hCC, 8'hCC, 8'hCC,
    8'hCD, 8'hCD, 8'hCD, 8'hCE, 8'hCE, 8'hCE, 8'hCF, 8'hD0,
    8'hD1, 8'hD2, 8'hD3, 8'hAC, 8'hD4, 8'hAD, 8'hD5, 8'hAE,
    8'hD6, 8'hD7, 8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDC,
    8'h00, 8'h00, 8'hA6, 8'hDD, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // One bit per table entry: the kana takes a voiced or a semi-voiced mark.
  localparam logic [TABLE_DEPTH-1:0] VOICED_SET = 128'h0000_0000_1249_02A5_5555_5000_0000_0000;
  localparam logic [TABLE_DEPTH-1:0] SEMI_SET   = 128'h0000_0000_2492_0000_0000_0000_0000_0000;

endpackage

`default_nettype wire

// ----- sv/utf8_katakana_to_halfwidth_kana.sv -----
// Top level of the UTF-8 katakana to JIS X 0201 half-width kana converter.
// A taken byte sits in the input register and is decoded from there into the output register.
// Throughput: one input byte per cycle while the output is not stalled; a voiced or semi-voiced
// kana stalls the next byte that gives a result until its mark moves into the output register.
// Bytes that give no result (sequence bytes, dropped bytes) never wait on the output side.
// Reset (rst_n low, synchronous) empties both registers and returns the decoder to idle.
`default_nettype none

module utf8_katakana_to_halfwidth_kana import u8kana_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input stream.
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  input  wire logic       in_tlast,   // end_of_text
  // Result stream.
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] display_code
  output logic            out_tlast   // last_of_run
);

  // Where the decoder stands inside a three-byte katakana sequence.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAD,
    PH_PAGE_LO,
    PH_PAGE_HI
  } phase_t;

  // Input register: one byte with its end-of-text flag.
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r,  in_byte_nxt;
  logic       in_eot_r,   in_eot_nxt;

  // Decoder state, advanced when the registered byte is consumed.
  phase_t     phase_r, phase_nxt;

  // Output register plus a one-deep holding slot for the trailing mark.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_code_r,  out_code_nxt;
  logic       out_last_r,  out_last_nxt;
  logic       mark_pend_r, mark_pend_nxt;
  logic [7:0] mark_code_r, mark_code_nxt;

  // Decode results for the byte in the input register.
  phase_t     dec_phase;
  logic       dec_emit;
  logic       dec_pair;
  logic [7:0] dec_code;
  logic [7:0] dec_mark;
  kana_idx_t  dec_idx;
  logic [7:0] dec_base;

  logic       load_ok;
  logic       consume;

  // Decode one byte against the current phase. The table is read whenever a third byte
  // sits in the input register; the result is only used for continuation bytes.
  always_comb begin
    dec_phase = phase_r;
    dec_emit  = 1'b0;
    dec_pair  = 1'b0;
    dec_code  = in_byte_r;
    dec_mark  = VOICED_MARK;
    dec_idx   = {(phase_r == PH_PAGE_HI), in_byte_r[5:0]};
    dec_base  = KANA_BASE[dec_idx];
    case (phase_r)
      PH_IDLE: begin
        if (in_byte_r == LEAD_BYTE) begin
          dec_phase = PH_LEAD;
        end else begin
          // Plain byte outside a sequence passes through unchanged.
          dec_emit = 1'b1;
        end
      end
      PH_LEAD: begin
        // A second byte other than the two katakana pages is dropped.
        if (in_byte_r == PAGE_LOW) begin
          dec_phase = PH_PAGE_LO;
        end else if (in_byte_r == PAGE_HIGH) begin
          dec_phase = PH_PAGE_HI;
        end else begin
          dec_phase = PH_IDLE;
        end
      end
      PH_PAGE_LO, PH_PAGE_HI: begin
        dec_phase = PH_IDLE;
        // Only continuation bytes with a table entry produce a kana.
        if (in_byte_r[7:6] == CONT_PREFIX && dec_base != NO_KANA) begin
          dec_emit = 1'b1;
          dec_code = dec_base;
          dec_pair = VOICED_SET[dec_idx] | SEMI_SET[dec_idx];
          dec_mark = SEMI_SET[dec_idx] ? SEMI_MARK : VOICED_MARK;
        end
      end
      default: begin
        dec_phase = PH_IDLE;
      end
    endcase
    // End of text abandons an unfinished sequence.
    if (in_eot_r) begin
      dec_phase = PH_IDLE;
    end
  end

  // The output register can take a new code when it is empty, or when its current code
  // leaves this cycle and no mark is waiting behind it.
  assign load_ok   = !out_valid_r || (out_tready && !mark_pend_r);
  // Bytes that produce nothing never wait on the output side.
  assign consume   = in_valid_r && (!dec_emit || load_ok);
  assign in_tready = !in_valid_r || consume;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_byte_nxt   = in_byte_r;
    in_eot_nxt    = in_eot_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    mark_pend_nxt = mark_pend_r;
    mark_code_nxt = mark_code_r;

    if (in_tready) begin
      in_valid_nxt = in_tvalid;
      in_byte_nxt  = in_tdata;
      in_eot_nxt   = in_tlast;
    end

    if (consume) begin
      phase_nxt = dec_phase;
    end

    // Drain: the current code leaves, and a waiting mark moves up behind it.
    if (out_valid_r && out_tready) begin
      if (mark_pend_r) begin
        out_code_nxt  = mark_code_r;
        out_last_nxt  = 1'b1;
        mark_pend_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end

    // Load: a new code, with its mark parked behind it for a voiced pair.
    if (consume && dec_emit) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = dec_code;
      out_last_nxt  = !dec_pair;
      mark_pend_nxt = dec_pair;
      mark_code_nxt = dec_mark;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
      mark_pend_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      mark_pend_r <= mark_pend_nxt;
    end
    in_byte_r   <= in_byte_nxt;
    in_eot_r    <= in_eot_nxt;
    out_code_r  <= out_code_nxt;
    out_last_r  <= out_last_nxt;
    mark_code_r <= mark_code_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_code_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  // A mark only waits behind a base kana that is still on the output.
  a_mark_behind_base: assert property (@(posedge clk) disable iff (!rst_n)
    mark_pend_r |-> (out_valid_r && !out_last_r))
    else $error("mark pending without a base kana on the output");

  // A code without the last flag always has its mark waiting.
  a_pair_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> mark_pend_r)
    else $error("base kana shown without a pending mark");

  // Once the base kana leaves, the mark follows as the final code of the byte.
  a_mark_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (mark_pend_r && out_tready) |=> (out_valid_r && out_tlast && !mark_pend_r))
    else $error("mark did not follow its base kana");

  // A waiting mark is one of the two mark codes.
  a_mark_code: assert property (@(posedge clk) disable iff (!rst_n)
    mark_pend_r |-> (mark_code_r == VOICED_MARK || mark_code_r == SEMI_MARK))
    else $error("pending mark holds a wrong code");

  // End of text leaves the decoder idle.
  a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && in_eot_r) |=> (phase_r == PH_IDLE))
    else $error("decoder not idle after end of text");
`endif

endmodule

`default_nettype wire

// ----- sim/utf8_katakana_to_halfwidth_kana_tb.sv -----
// Self-checking testbench for the UTF-8 katakana to half-width kana converter.
`timescale 1ns / 1ps

module utf8_katakana_to_halfwidth_kana_tb import u8kana_pkg::*;;

  // Cycles in which no request moves on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Length of the long output hold-off used to fill the block and stall its input.
  localparam int LONG_HOLD      = 300;
  // Length of the wait after the last expected code.
  localparam int DRAIN_CYCLES   = 12;
  // Input bytes to send in total.
  localparam int TARGET_BYTES   = 950;

  // Where the decoder stands inside a three-byte katakana sequence.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_AFTER_LEAD,
    PH_PAGE_LOW,
    PH_PAGE_HIGH
  } decode_phase_e;

  // Mark that follows a base kana.
  typedef enum logic [1:0] {
    MARK_NONE,
    MARK_VOICED,
    MARK_SEMI
  } kana_mark_e;

  // Stall patterns of the result receiver.
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE_STALL,
    RX_PERIODIC
  } rx_mode_e;

  // One expected result request.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } display_req_t;

  // Half-width base kana, indexed by {page is 83, low six bits of the third byte}.
  // A zero entry means the third byte has no kana.
  localparam logic [7:0] HALFWIDTH_BASE [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'hA7, 8'hB1, 8'hA8, 8'hB2, 8'hA9, 8'hB3, 8'hAA,
    8'hB4, 8'hAB, 8'hB5, 8'hB6, 8'hB6, 8'hB7, 8'hB7, 8'hB8,
    8'hB8, 8'hB9, 8'hB9, 8'hBA, 8'hBA, 8'hBB, 8'hBB, 8'hBC,
    8'hBC, 8'hBD, 8'hBD, 8'hBE, 8'hBE, 8'hBF, 8'hBF, 8'hC0,
    8'hC0, 8'hC1, 8'hC1, 8'hAF, 8'hC2, 8'hC2, 8'hC3, 8'hC3,
    8'hC4, 8'hC4, 8'hC5, 8'hC6, 8'hC7, 8'hC8, 8'hC9, 8'hCA,
    8'hCA, 8'hCA, 8'hCB, 8'hCB, 8'hCB, 8'hCC, 8'hCC, 8'hCC,
    8'hCD, 8'hCD, 8'hCD, 8'hCE, 8'hCE, 8'hCE, 8'hCF, 8'hD0,
    8'hD1, 8'hD2, 8'hD3, 8'hAC, 8'hD4, 8'hAD, 8'hD5, 8'hAE,
    8'hD6, 8'hD7, 8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDC,
    8'h00, 8'h00, 8'hA6, 8'hDD, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] text_byte
  logic       in_tlast;   // end_of_text
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;  // [7:0] display_code
  logic       out_tlast;  // last_of_run

  // Predicted display codes, oldest first, and the predictor's own decoder phase.
  display_req_t  pending_codes [$];
  decode_phase_e decode_phase = PH_IDLE;

  int mismatch_count  = 0;
  int bytes_sent      = 0;
  int burst_left      = 0;
  int idle_cycles     = 0;
  // The test sequence bumps this to ask the receiver for one long hold-off.
  int long_stall_req  = 0;

  utf8_katakana_to_halfwidth_kana i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mark that goes with a table entry; every other entry takes none.
  function automatic kana_mark_e mark_of(logic [6:0] idx);
    case (idx)
      44, 46, 48, 50, 52, 54, 56, 58, 60, 62,
      64, 66, 69, 71, 73, 80, 83, 86, 89, 92: return MARK_VOICED;
      81, 84, 87, 90, 93:                     return MARK_SEMI;
      default:                                return MARK_NONE;
    endcase
  endfunction

  // Works out the display codes that one accepted text byte causes and queues them.
  function automatic void predict_display_codes(logic [7:0] text_byte, logic end_of_text);
    logic [6:0] idx;
    logic [7:0] base;
    kana_mark_e mark;
    case (decode_phase)
      PH_IDLE: begin
        if (text_byte == LEAD_BYTE) begin
          decode_phase = PH_AFTER_LEAD;
        end else begin
          pending_codes.push_back(display_req_t'{text_byte, 1'b1});
        end
      end
      PH_AFTER_LEAD: begin
        // Any second byte other than the two katakana pages is dropped.
        if (text_byte == PAGE_LOW) begin
          decode_phase = PH_PAGE_LOW;
        end else if (text_byte == PAGE_HIGH) begin
          decode_phase = PH_PAGE_HIGH;
        end else begin
          decode_phase = PH_IDLE;
        end
      end
      default: begin
        idx = {decode_phase == PH_PAGE_HIGH, text_byte[5:0]};
        decode_phase = PH_IDLE;
        // Only a continuation byte with a table entry gives a kana.
        if (text_byte[7:6] == CONT_PREFIX) begin
          base = HALFWIDTH_BASE[idx];
          mark = mark_of(idx);
          if (base != NO_KANA) begin
            if (mark == MARK_NONE) begin
              pending_codes.push_back(display_req_t'{base, 1'b1});
            end else begin
              pending_codes.push_back(display_req_t'{base, 1'b0});
              pending_codes.push_back(display_req_t'{
                (mark == MARK_VOICED) ? VOICED_MARK : SEMI_MARK, 1'b1});
            end
          end
        end
      end
    endcase
    // End of text abandons whatever sequence is still open.
    if (end_of_text) begin
      decode_phase = PH_IDLE;
    end
  endfunction

  // Offers one text byte and waits until the block takes the request. The sender works in
  // bursts: when a burst runs out, valid drops for a random gap before the next one starts.
  // Valid is never lowered after acceptance here, so back-to-back bytes keep it high.
  task automatic send_text_byte(input logic [7:0] text_byte, input logic end_of_text);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      // Mostly short bursts, now and then a long stretch with no gaps at all.
      burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16) : $urandom_range(40, 120);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= text_byte;
    in_tlast  <= end_of_text;
    do @(posedge clk); while (!in_tready);
    predict_display_codes(text_byte, end_of_text);
    bytes_sent++;
  endtask

  // Sends a full three-byte sequence with end of text on the last byte only.
  task automatic send_sequence(input logic [7:0] page, input logic [7:0] third,
                               input logic end_of_text);
    send_text_byte(LEAD_BYTE, 1'b0);
    send_text_byte(page, 1'b0);
    send_text_byte(third, end_of_text);
  endtask

  // End of text shows up on roughly one byte in twenty.
  function automatic logic random_eot();
    return ($urandom_range(0, 19) == 0);
  endfunction

  function automatic logic [7:0] random_page();
    return $urandom_range(0, 1) ? PAGE_HIGH : PAGE_LOW;
  endfunction

  // One random piece of text. Most pieces are well-formed katakana, so the decoder gets
  // past its first phases; the rest are raw bytes and broken or cut-off sequences.
  task automatic send_random_text_unit();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_text_byte(LEAD_BYTE, random_eot());
      send_text_byte(random_page(), random_eot());
      send_text_byte({CONT_PREFIX, 6'($urandom_range(0, 63))}, random_eot());
    end else if (pick < 75) begin
      send_text_byte(8'($urandom_range(0, 255)), random_eot());
    end else if (pick < 85) begin
      send_text_byte(LEAD_BYTE, random_eot());
      send_text_byte(8'($urandom_range(0, 255)), random_eot());
    end else if (pick < 95) begin
      send_text_byte(LEAD_BYTE, random_eot());
      send_text_byte(random_page(), random_eot());
      send_text_byte(8'($urandom_range(0, 255)), random_eot());
    end else begin
      // A sequence cut short by end of text.
      send_text_byte(LEAD_BYTE, 1'($urandom_range(0, 1)));
      send_text_byte(random_page(), 1'b1);
    end
  endtask

  // Bytes outside a sequence pass through, both extremes included.
  task automatic test_passthrough();
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b1);
  endtask

  task automatic test_plain_kana();
    send_sequence(PAGE_LOW, 8'hA1, 1'b0);
  endtask

  // A voiced kana gives its base kana and then the voiced mark.
  task automatic test_voiced_kana();
    send_sequence(PAGE_LOW, 8'hAC, 1'b0);
  endtask

  task automatic test_semi_voiced_kana();
    send_sequence(PAGE_HIGH, 8'h91, 1'b0);
  endtask

  // Small wa comes out as plain wa.
  task automatic test_small_wa();
    send_sequence(PAGE_HIGH, 8'hAE, 1'b0);
  endtask

  // A second lead byte after the lead is a bad second byte and is dropped;
  // the page byte that follows is then a fresh byte and passes raw.
  task automatic test_bad_second_byte();
    send_text_byte(LEAD_BYTE, 1'b0);
    send_text_byte(LEAD_BYTE, 1'b0);
    send_text_byte(PAGE_LOW, 1'b0);
  endtask

  // A third byte with no table entry, inside and outside the continuation range.
  task automatic test_unmapped_third_byte();
    send_sequence(PAGE_LOW, 8'h80, 1'b0);
    send_sequence(PAGE_HIGH, 8'hC0, 1'b0);
  endtask

  // End of text on the lead byte abandons the sequence, so the page byte passes raw.
  task automatic test_end_of_text();
    send_text_byte(LEAD_BYTE, 1'b1);
    send_text_byte(PAGE_HIGH, 1'b0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering without
  // gaps, so the block fills up and drops its input ready.
  task automatic test_backpressure();
    long_stall_req++;
    burst_left = 200;
    repeat (20) send_random_text_unit();
  endtask

  task automatic test_random_text();
    while (bytes_sent < TARGET_BYTES) begin
      send_random_text_unit();
    end
  endtask

  // Result receiver: a random stall pattern that changes every so often, and a long
  // hold-off whenever one is asked for, counted here cycle by cycle.
  int       hold_left      = 0;
  int       stall_req_seen = 0;
  int       mode_left      = 0;
  int       rx_cycle       = 0;
  rx_mode_e rx_mode        = RX_STEADY;

  always @(negedge clk) begin
    rx_cycle++;
    if (long_stall_req != stall_req_seen) begin
      stall_req_seen = long_stall_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_STEADY:       out_tready <= 1'b1;
        RX_COIN:         out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE_STALL: out_tready <= ($urandom_range(0, 9) != 0);
        default:         out_tready <= ((rx_cycle % 5) < 3);
      endcase
    end
  end

  // Each accepted result request is checked against the oldest prediction.
  always @(posedge clk) begin
    display_req_t oldest;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_codes.size() == 0) begin
        $error("unexpected result: display_code %h last_of_run %b", out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        oldest = pending_codes.pop_front();
        if (out_tdata !== oldest.code) begin
          $error("display_code: expected %h, actual %h", oldest.code, out_tdata);
          mismatch_count++;
        end
        if (out_tlast !== oldest.last) begin
          $error("last_of_run: expected %b, actual %b", oldest.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends a run in which no request has moved on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    rst_n     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_passthrough();
    test_plain_kana();
    test_voiced_kana();
    test_semi_voiced_kana();
    test_small_wa();
    test_bad_second_byte();
    test_unmapped_third_byte();
    test_end_of_text();
    test_backpressure();
    test_random_text();

    @(negedge clk);
    in_tvalid <= 1'b0;
    // The watchdog bounds this wait if a result never shows up.
    while (pending_codes.size() != 0) @(posedge clk);
    // Anything that still comes out now is flagged as unexpected by the checker.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
